// ===== design/rdpd_pkg.sv =====
// Shared types and byte codes for the remote debug packet deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package rdpd_pkg;

  // Framing byte codes.
  localparam logic [7:0] BYTE_INTERRUPT  = 8'h03;
  localparam logic [7:0] BYTE_ESCAPE_XOR = 8'h20;
  localparam logic [7:0] BYTE_START      = 8'h24;
  localparam logic [7:0] BYTE_HASH       = 8'h23;
  localparam logic [7:0] BYTE_ESCAPE     = 8'h7D;

  // Checksum character count while inside a packet.
  localparam logic [1:0] CKS_NONE  = 2'd0;
  localparam logic [1:0] CKS_FIRST = 2'd1;
  localparam logic [1:0] CKS_SECOND = 2'd2;

  // Event codes carried by a result transfer.
  typedef enum logic [2:0] {
    KIND_START     = 3'd0,
    KIND_PAYLOAD   = 3'd1,
    KIND_END       = 3'd2,
    KIND_INTERRUPT = 3'd3,
    KIND_ABORT     = 3'd4
  } rdpd_kind_e;

  // One result item as it travels from the framer to the output stage.
  typedef struct packed {
    rdpd_kind_e  kind;
    logic [7:0]  payload;
    logic [7:0]  cks_first;
    logic [7:0]  cks_second;
    logic        send_ack;
  } rdpd_result_t;

endpackage

`default_nettype wire

// ===== design/rdpd_framer.sv =====
// Framing state machine: decodes one byte against the packet state.
// Depends on rdpd_pkg for byte codes and the result type.
`default_nettype none

module rdpd_framer (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [7:0]            raw_byte_i,
  input  wire logic                  advance_i,
  output logic                       has_result_o,
  output rdpd_pkg::rdpd_result_t     result_o
);
  import rdpd_pkg::*;

  logic       inside_q, inside_d;
  logic       esc_q, esc_d;
  logic [1:0] cks_q, cks_d;
  logic [7:0] held_q, held_d;

  // Next state and result for the byte at the head of the input register.
  always_comb begin
    inside_d     = inside_q;
    esc_d        = esc_q;
    cks_d        = cks_q;
    held_d       = held_q;
    has_result_o = 1'b0;
    result_o     = '{kind: KIND_START, payload: 8'h00, cks_first: 8'h00,
                     cks_second: 8'h00, send_ack: 1'b0};

    if (!inside_q) begin
      // Idle: only interrupt and start bytes mean anything.
      if (raw_byte_i == BYTE_INTERRUPT) begin
        has_result_o     = 1'b1;
        result_o.kind    = KIND_INTERRUPT;
        result_o.payload = BYTE_INTERRUPT;
      end else if (raw_byte_i == BYTE_START) begin
        inside_d     = 1'b1;
        esc_d        = 1'b0;
        cks_d        = CKS_NONE;
        has_result_o = 1'b1;
      end
    end else if (cks_q == CKS_FIRST) begin
      // First checksum character is held until the second arrives.
      held_d = raw_byte_i;
      cks_d  = CKS_SECOND;
    end else if (cks_q[1]) begin
      // Second checksum character closes the packet.
      has_result_o        = 1'b1;
      result_o.kind       = KIND_END;
      result_o.cks_first  = held_q;
      result_o.cks_second = raw_byte_i;
      result_o.send_ack   = 1'b1;
      inside_d            = 1'b0;
      esc_d               = 1'b0;
      cks_d               = CKS_NONE;
    end else if (esc_q) begin
      esc_d            = 1'b0;
      has_result_o     = 1'b1;
      result_o.kind    = KIND_PAYLOAD;
      result_o.payload = raw_byte_i ^ BYTE_ESCAPE_XOR;
    end else if (raw_byte_i == BYTE_ESCAPE) begin
      esc_d = 1'b1;
    end else if (raw_byte_i == BYTE_START) begin
      has_result_o  = 1'b1;
      result_o.kind = KIND_ABORT;
    end else if (raw_byte_i == BYTE_HASH) begin
      cks_d = CKS_FIRST;
    end else begin
      has_result_o     = 1'b1;
      result_o.kind    = KIND_PAYLOAD;
      result_o.payload = raw_byte_i;
    end
  end

  // Packet state moves only when the byte is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      esc_q    <= 1'b0;
      cks_q    <= CKS_NONE;
      held_q   <= 8'h00;
    end else if (advance_i) begin
      inside_q <= inside_d;
      esc_q    <= esc_d;
      cks_q    <= cks_d;
      held_q   <= held_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/rdpd_out_stage.sv =====
// Result register that drives the output channel.
// Depends on rdpd_pkg for the result type.
`default_nettype none

module rdpd_out_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire rdpd_pkg::rdpd_result_t result_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output rdpd_pkg::rdpd_result_t     result_o
);
  import rdpd_pkg::*;

  logic         valid_q;
  rdpd_result_t data_q;

  // The register can take a new result when empty or when it is being drained.
  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // Payload holds while stalled.
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/remote_debug_packet_deframer_core.sv =====
// Top level of the remote debug packet deframer.
// Instantiates rdpd_framer and rdpd_out_stage; depends on rdpd_pkg.
//
// Usage:
//   Input channel (in_valid_i, in_stall_o, raw_byte_i) takes one link byte per
//   transfer. Output channel (out_valid_o, out_stall_i, event_kind_o and the
//   field ports) gives one event per transfer; many bytes give no event.
//   A byte moves into an input register, is decoded against the packet state
//   and lands in the result register, which drives the output channel. One
//   byte per cycle is sustained: the framer consumes the held byte in every
//   cycle in which the result register is empty or drained, and at once when
//   the byte gives no event.
//   While the receiver stalls a full result register, a byte that gives an
//   event waits in the input register and in_stall_o is raised; the output
//   payload holds steady.
//   Reset clears the valid flags of both registers and returns the framer to idle,
//   outside any packet, with no escape or checksum pending.
`default_nettype none

module remote_debug_packet_deframer_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] raw_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      event_kind_o,
  output logic [7:0]      payload_byte_o,
  output logic [7:0]      checksum_first_char_o,
  output logic [7:0]      checksum_second_char_o,
  output logic            send_ack_o
);
  import rdpd_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         has_result;
  logic         out_free;
  logic         advance;
  rdpd_result_t framer_result;
  rdpd_result_t out_result;

  // The held byte is consumed unless its event has nowhere to go.
  assign advance    = in_valid_q && (!has_result || out_free);
  assign in_stall_o = in_valid_q && !advance;

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register byte.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= raw_byte_i;
    end
  end

  rdpd_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .raw_byte_i   (in_byte_q),
    .advance_i    (advance),
    .has_result_o (has_result),
    .result_o     (framer_result)
  );

  rdpd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_result),
    .result_i    (framer_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  // Output field ports.
  assign event_kind_o           = out_result.kind;
  assign payload_byte_o         = out_result.payload;
  assign checksum_first_char_o  = out_result.cks_first;
  assign checksum_second_char_o = out_result.cks_second;
  assign send_ack_o             = out_result.send_ack;

  // Input backpressure only ever comes from a stalled, full result register.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A stalled result is never dropped.
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result was lost");

  // The acknowledge request travels only with a packet end event.
  a_ack_with_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && send_ack_o) |-> (event_kind_o == KIND_END))
    else $error("acknowledge request outside packet end");

  // A byte that gives no event never waits in the input register.
  a_silent_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !has_result) |-> !in_stall_o)
    else $error("silent byte was held");

endmodule

`default_nettype wire
